[src/bwl_pkg.sv]
// ----------------------------------------------------------------------------
// bwl_pkg
// Types and constants shared by the bounded-wait lock arbiter and its channels.
// ----------------------------------------------------------------------------
package bwl_pkg;

   localparam int ID_W     = 6;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   localparam logic REQ_ACQUIRE = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED  = 3'd0,
      ST_QUEUED   = 3'd1,
      ST_HANDOFF  = 3'd2,
      ST_FREED    = 3'd3,
      ST_REJECTED = 3'd4
   } status_type;

   typedef struct packed {
      status_type          status;
      logic [ID_W-1:0]     handoff_id;
   } rsp_item_type;

endpackage

[src/bwl_req_if.sv]
// ----------------------------------------------------------------------------
// bwl_req_if
// Request channel: acquire or release by one client.
// ----------------------------------------------------------------------------
interface bwl_req_if;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [bwl_pkg::ID_W-1:0]  proc_id;

   modport source (output valid, output req_type, output proc_id, input ready);
   modport sink   (input valid, input req_type, input proc_id, output ready);
endinterface

[src/bwl_rsp_if.sv]
// ----------------------------------------------------------------------------
// bwl_rsp_if
// Result channel: outcome of one request item.
// ----------------------------------------------------------------------------
interface bwl_rsp_if;
   logic                      valid;
   logic                      ready;
   bwl_pkg::status_type       status;
   logic [bwl_pkg::ID_W-1:0]  handoff_id;

   modport source (output valid, output status, output handoff_id, input ready);
   modport sink   (input valid, input status, input handoff_id, output ready);
endinterface

[src/bounded_wait_lock_arbiter.sv]
// ----------------------------------------------------------------------------
// bounded_wait_lock_arbiter
// Mutex with one waiting bit per client and round-robin handoff on release.
// ----------------------------------------------------------------------------
// Takes one request item per cycle while req.ready is high. Each item is
// resolved in the cycle it is accepted against the current lock and waiting
// bits (rotate-free find-first over the waiting bits above and below the
// releaser), and its result is registered in the output buffer before it
// appears on rsp. Results go through a two-entry output buffer, so req stays
// ready while one result waits; req.ready drops only while two results are
// held. active_count is written through csr_write_enable / csr_write_data;
// values of 0 act as 1 and values above the client limit saturate to it.
// ----------------------------------------------------------------------------
module bounded_wait_lock_arbiter #(
   parameter int NUM_CLIENTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   bwl_req_if.sink                       req,
   bwl_rsp_if.source                     rsp,
   input  logic                          csr_write_enable,
   input  logic [bwl_pkg::COUNT_W-1:0]   csr_write_data
);

   localparam int LIMIT = (NUM_CLIENTS < 64) ? NUM_CLIENTS : 64;

   logic [bwl_pkg::COUNT_W-1:0] active_count_ff;
   logic                        lock_held_ff, lock_held_in;
   logic [LIMIT-1:0]            waiting_ff, waiting_in;

   bwl_pkg::rsp_item_type head_ff, skid_ff, result;
   logic                  head_valid_ff, skid_valid_ff;

   logic [bwl_pkg::COUNT_W-1:0] eff_count;
   logic [LIMIT-1:0]            id_bit, in_range, above, cand, upper;
   logic [bwl_pkg::ID_W-1:0]    upper_idx, any_idx;
   logic                        accept, pop;

   assign accept = req.valid & req.ready;
   assign pop    = head_valid_ff & rsp.ready;

   always_comb begin
      if (active_count_ff == '0) begin
         eff_count = bwl_pkg::COUNT_W'(1);
      end else if (active_count_ff > bwl_pkg::COUNT_W'(LIMIT)) begin
         eff_count = bwl_pkg::COUNT_W'(LIMIT);
      end else begin
         eff_count = active_count_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < LIMIT; k++) begin
         id_bit[k]   = (bwl_pkg::ID_W'(k) == req.proc_id);
         above[k]    = (bwl_pkg::ID_W'(k) > req.proc_id);
         in_range[k] = (bwl_pkg::COUNT_W'(k) < eff_count);
      end
      cand  = waiting_ff & in_range & ~id_bit;
      upper = cand & above;
      upper_idx = '0;
      any_idx   = '0;
      for (int k = LIMIT - 1; k >= 0; k--) begin
         if (upper[k]) begin
            upper_idx = bwl_pkg::ID_W'(k);
         end
         if (cand[k]) begin
            any_idx = bwl_pkg::ID_W'(k);
         end
      end
   end

   always_comb begin
      lock_held_in      = lock_held_ff;
      waiting_in        = waiting_ff;
      result.status     = bwl_pkg::ST_REJECTED;
      result.handoff_id = '0;
      if ({1'b0, req.proc_id} >= eff_count) begin
         result.status = bwl_pkg::ST_REJECTED;
      end else if (req.req_type == bwl_pkg::REQ_ACQUIRE) begin
         if (!lock_held_ff) begin
            lock_held_in  = 1'b1;
            waiting_in    = waiting_ff & ~id_bit;
            result.status = bwl_pkg::ST_GRANTED;
         end else begin
            waiting_in    = waiting_ff | id_bit;
            result.status = bwl_pkg::ST_QUEUED;
         end
      end else begin
         waiting_in = waiting_ff & ~id_bit;
         if (!lock_held_ff || cand == '0) begin
            lock_held_in  = 1'b0;
            result.status = bwl_pkg::ST_FREED;
         end else begin
            result.status     = bwl_pkg::ST_HANDOFF;
            result.handoff_id = (upper != '0) ? upper_idx : any_idx;
            for (int k = 0; k < LIMIT; k++) begin
               if (bwl_pkg::ID_W'(k) == result.handoff_id) begin
                  waiting_in[k] = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff <= bwl_pkg::COUNT_W'(1);
         lock_held_ff    <= 1'b0;
         waiting_ff      <= '0;
         head_valid_ff   <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            active_count_ff <= csr_write_data;
         end
         if (accept) begin
            lock_held_ff <= lock_held_in;
            waiting_ff   <= waiting_in;
         end
         if (skid_valid_ff) begin
            if (pop) begin
               head_ff       <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (!head_valid_ff || pop) begin
               head_ff       <= result;
               head_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= result;
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            head_valid_ff <= 1'b0;
         end
      end
   end

   assign req.ready      = ~skid_valid_ff;
   assign rsp.valid      = head_valid_ff;
   assign rsp.status     = head_ff.status;
   assign rsp.handoff_id = head_ff.handoff_id;

endmodule

[tb/sv/bwl_lock_checker.sv]
// ----------------------------------------------------------------------------
// bwl_lock_checker
// Watches the request, result and register ports of the lock arbiter. It keeps
// its own lock bit, waiting bits and client count and predicts the outcome of
// every accepted request item. Each accepted result is compared field by field
// with the oldest prediction. Failures and outstanding predictions are
// reported to the testbench top.
// ----------------------------------------------------------------------------
module bwl_lock_checker #(
   parameter int NUM_CLIENTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   bwl_req_if                            req,
   bwl_rsp_if                            rsp,
   input  logic                          csr_write_enable,
   input  logic [bwl_pkg::COUNT_W-1:0]   csr_write_data,
   output int                            failures,
   output int                            results_pending
);

   import bwl_pkg::*;

   logic                lock_taken;
   logic [63:0]         waiters;
   logic [COUNT_W-1:0]  client_count;
   rsp_item_type        predicted_q[$];
   int                  reported;

   function automatic int clients_in_ring();
      int limit;
      int n;
      limit = (NUM_CLIENTS < 64) ? NUM_CLIENTS : 64;
      if (limit < 1) limit = 1;
      n = int'(client_count);
      if (n < 1) n = 1;
      if (n > limit) n = limit;
      return n;
   endfunction

   function automatic rsp_item_type resolve_lock_request(logic kind, logic [ID_W-1:0] id);
      rsp_item_type outcome;
      int           n;
      int           j;
      n = clients_in_ring();
      outcome.status     = ST_REJECTED;
      outcome.handoff_id = '0;
      if (int'(id) >= n) begin
         outcome.status = ST_REJECTED;
      end else if (kind == REQ_ACQUIRE) begin
         if (!lock_taken) begin
            lock_taken  = 1'b1;
            waiters[id] = 1'b0;
            outcome.status = ST_GRANTED;
         end else begin
            waiters[id] = 1'b1;
            outcome.status = ST_QUEUED;
         end
      end else begin
         waiters[id] = 1'b0;
         if (!lock_taken) begin
            outcome.status = ST_FREED;
         end else begin
            // round-robin search from the releaser's successor
            j = (int'(id) + 1) % n;
            while (j != int'(id) && !waiters[j]) j = (j + 1) % n;
            if (j == int'(id)) begin
               lock_taken = 1'b0;
               outcome.status = ST_FREED;
            end else begin
               waiters[j] = 1'b0;
               outcome.status     = ST_HANDOFF;
               outcome.handoff_id = ID_W'(j);
            end
         end
      end
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         lock_taken   = 1'b0;
         waiters      = '0;
         client_count = COUNT_W'(1);
         failures     = 0;
         reported     = 0;
         predicted_q.delete();
      end else begin
         if (csr_write_enable) client_count = csr_write_data;
         if (req.valid === 1'b1 && req.ready === 1'b1)
            predicted_q.push_back(resolve_lock_request(req.req_type, req.proc_id));
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (predicted_q.size() == 0) begin
               failures++;
               if (reported < 10) begin
                  reported++;
                  $display("unexpected result item: status %0d handoff %0d",
                           rsp.status, rsp.handoff_id);
               end
            end else begin
               want = predicted_q.pop_front();
               if (rsp.status !== want.status || rsp.handoff_id !== want.handoff_id) begin
                  failures++;
                  if (reported < 10) begin
                     reported++;
                     $display("result mismatch: expected status %0d handoff %0d,",
                              want.status, want.handoff_id,
                              " got status %0d handoff %0d",
                              rsp.status, rsp.handoff_id);
                  end
               end
            end
         end
      end
      results_pending = predicted_q.size();
   end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the bounded-wait lock arbiter. A directed part covers grants,
// queueing, wrap-around handoff, release of a free lock, rejected ids, count
// clamping and stale waiters; then random phases run under different client
// counts, each with or without random gaps on the request side and stalls on
// the result side. The checker beside the block predicts and compares; this
// module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   import bwl_pkg::*;

   localparam int NUM_CLIENTS  = 64;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 75;

   logic                clock;
   logic                reset;
   logic                csr_write_enable;
   logic [COUNT_W-1:0]  csr_write_data;

   bwl_req_if req ();
   bwl_rsp_if rsp ();

   int  failures;
   int  results_pending;
   int  cycles;
   int  stall_left;
   int  ring_size;
   bit  sender_gaps;
   bit  receiver_stalls;

   bounded_wait_lock_arbiter #(.NUM_CLIENTS(NUM_CLIENTS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   bwl_lock_checker #(.NUM_CLIENTS(NUM_CLIENTS)) lock_checker (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .results_pending  (results_pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp.ready <= 1'b0;
         stall_left--;
      end else if (receiver_stalls && $urandom_range(0, 99) < 25) begin
         rsp.ready <= 1'b0;
         stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                   : $urandom_range(7, 39);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   function automatic int pick_gap();
      int r;
      if (!sender_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // entered and left at a falling edge
   task automatic send_request(input logic kind, input logic [ID_W-1:0] id);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid    <= 1'b1;
      req.req_type <= kind;
      req.proc_id  <= id;
      do @(posedge clock); while (req.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic wait_results();
      req.valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
   endtask

   task automatic set_client_count(input logic [COUNT_W-1:0] value);
      wait_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (value == 0) ring_size = 1;
      else if (int'(value) > NUM_CLIENTS) ring_size = NUM_CLIENTS;
      else ring_size = int'(value);
   endtask

   initial begin
      logic              kind;
      logic [ID_W-1:0]   id;
      logic [COUNT_W-1:0] count;

      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req.valid        = 1'b0;
      req.req_type     = REQ_ACQUIRE;
      req.proc_id      = '0;
      ring_size        = 1;
      sender_gaps      = 1'b1;
      receiver_stalls  = 1'b1;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single client after reset
      send_request(REQ_ACQUIRE, 6'd0);
      send_request(REQ_ACQUIRE, 6'd0);
      send_request(REQ_ACQUIRE, 6'd63);
      send_request(REQ_RELEASE, 6'd0);
      send_request(REQ_RELEASE, 6'd0);

      // full ring, handoff including wrap-around
      set_client_count(7'd64);
      send_request(REQ_ACQUIRE, 6'd0);
      send_request(REQ_ACQUIRE, 6'd63);
      send_request(REQ_ACQUIRE, 6'd5);
      send_request(REQ_RELEASE, 6'd0);
      send_request(REQ_RELEASE, 6'd5);
      send_request(REQ_ACQUIRE, 6'd1);
      send_request(REQ_RELEASE, 6'd63);
      send_request(REQ_RELEASE, 6'd1);

      // zero count acts as one
      set_client_count(7'd0);
      send_request(REQ_ACQUIRE, 6'd1);
      send_request(REQ_ACQUIRE, 6'd0);
      send_request(REQ_RELEASE, 6'd0);

      // saturated count, then stale waiter above a lowered count
      set_client_count(7'd127);
      send_request(REQ_ACQUIRE, 6'd10);
      send_request(REQ_ACQUIRE, 6'd40);
      set_client_count(7'd8);
      send_request(REQ_RELEASE, 6'd10);
      send_request(REQ_ACQUIRE, 6'd40);
      set_client_count(7'd64);
      send_request(REQ_ACQUIRE, 6'd3);
      send_request(REQ_RELEASE, 6'd3);
      send_request(REQ_RELEASE, 6'd40);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       count = 7'd2;
            1:       count = 7'd64;
            2:       count = COUNT_W'($urandom_range(3, 16));
            3:       count = 7'd1;
            4:       count = COUNT_W'($urandom_range(17, 63));
            5:       count = COUNT_W'($urandom_range(65, 127));
            6:       count = 7'd4;
            default: count = COUNT_W'($urandom_range(0, 127));
         endcase
         set_client_count(count);
         sender_gaps     = (phase != 3) && ($urandom_range(0, 3) != 0);
         receiver_stalls = (phase != 3) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            kind = ($urandom_range(0, 99) < 55) ? REQ_ACQUIRE : REQ_RELEASE;
            if ($urandom_range(0, 99) < 88) id = ID_W'($urandom_range(0, ring_size - 1));
            else id = ID_W'($urandom_range(0, 63));
            send_request(kind, id);
         end
      end

      wait_results();
      repeat (10) @(negedge clock);
      if (failures == 0 && results_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
